// ===== hw/rtl/sobel_pkg.sv =====
// ---------------------------------------------------------------------------
// Sobel edge unit package
// Shared types and constants for the controller and the datapath.
// ---------------------------------------------------------------------------
package sobel_pkg;

  localparam int DefMaxWidth  = 1024;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 13;
  localparam int WidthRegW    = 11;
  localparam int HeightRegW   = 13;
  localparam int RowW         = 13;
  localparam int RootSteps    = 8;
  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd480;
  localparam logic [20:0]           SatLimit    = 21'd65280;
  localparam logic [7:0]            PixMax      = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic grad;
    logic square;
    logic root_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic have;
    logic out_free;
    logic pos_zero;
  } status_t;

endpackage

// ===== hw/rtl/sobel_ctrl.sv =====
// ---------------------------------------------------------------------------
// Sobel edge unit controller
// Sequences a word: update, then for a result gradient, square, root, output.
// ---------------------------------------------------------------------------
module sobel_ctrl import sobel_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t stat_i,
  output cmd_t    cmd_o,
  output logic    idle_o
);

  state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = stat_i.have ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD:   state_d = ST_SQUARE;
      ST_SQUARE: begin
        state_d = ST_ROOT;
        cnt_d   = '0;
      end
      ST_ROOT: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(RootSteps - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    idle_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idle_o        = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_UPDATE: cmd_o.update    = 1'b1;
      ST_GRAD:   cmd_o.grad      = 1'b1;
      ST_SQUARE: cmd_o.square    = 1'b1;
      ST_ROOT:   cmd_o.root_step = 1'b1;
      ST_OUT:    cmd_o.load_out  = stat_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/sobel_dp.sv =====
// ---------------------------------------------------------------------------
// Sobel edge unit datapath
// Line buffer memory, 3x3 window, stream position, gradients, root and output.
// ---------------------------------------------------------------------------
module sobel_dp import sobel_pkg::*; #(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             stat_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                op_i,
  input  logic [7:0]          in_red_i,
  input  logic [7:0]          in_green_i,
  input  logic [7:0]          in_blue_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          edge_red_o,
  output logic [7:0]          edge_green_o,
  output logic [7:0]          edge_blue_o,
  output logic                frame_end_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int WX = (WW > WidthRegW) ? WW : WidthRegW;

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [AW-1:0]         col_q;
  logic [RowW-1:0]       row_q;
  logic [47:0]           line_mem [MAX_WIDTH];
  logic [47:0]           rd_q;
  logic [23:0]           pix_q;
  logic [23:0]           win_q [9];
  logic                  top_q, bot_q, left_q, right_q, fe_q;

  logic [WX-1:0]         wr_ext;
  logic [WW-1:0]         w_eff, col_w, col_n, ocol;
  logic [RowW-1:0]       h_eff, orow, row_n;
  logic                  have, fe_hit;

  logic signed [10:0]    gx_q [3], gy_q [3];
  logic signed [10:0]    gx_d [3], gy_d [3];
  logic [15:0]           sq_q [3];
  logic                  sat_q [3];
  logic [9:0]            rem_q [3];
  logic [7:0]            root_q [3];
  logic [7:0]            res [3];
  logic                  out_valid_q;
  logic [7:0]            out_q [3];
  logic                  out_fe_q;

  assign wr_ext = WX'(width_q);
  always_comb begin
    if (width_q == '0) w_eff = WW'(1);
    else if (wr_ext > WX'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(wr_ext);
  end
  assign h_eff = (height_q == '0) ? RowW'(1) : height_q;
  assign col_w = WW'(col_q);

  // The window center lies one row and one column behind the incoming word.
  always_comb begin
    if (col_q == '0) begin
      have = (row_q >= RowW'(2));
      ocol = w_eff - WW'(1);
      orow = row_q - RowW'(2);
    end else begin
      have = (row_q >= RowW'(1));
      ocol = col_w - WW'(1);
      orow = row_q - RowW'(1);
    end
    if (orow >= h_eff) have = 1'b0;
    fe_hit = have && (orow == h_eff - RowW'(1)) && (ocol == w_eff - WW'(1));
    col_n  = col_w + WW'(1);
    row_n  = row_q;
    if (col_n >= w_eff) begin
      col_n = '0;
      if (row_q != '1) row_n = row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) width_q <= cfg_data_i[WidthRegW-1:0];
      else height_q <= cfg_data_i[HeightRegW-1:0];
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.update) begin
      if (fe_hit) begin
        col_q <= '0;
        row_q <= '0;
      end else begin
        col_q <= col_n[AW-1:0];
        row_q <= row_n;
      end
    end
  end

  // Each entry holds the upper row pixel above the middle row pixel.
  always_ff @(posedge clk_i) begin
    rd_q <= line_mem[col_q];
    if (cmd_i.update) line_mem[col_q] <= {rd_q[23:0], pix_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) pix_q <= op_i ? 24'd0 : {in_red_i, in_green_i, in_blue_i};
    if (cmd_i.update) begin
      top_q   <= (orow == '0);
      bot_q   <= (orow == h_eff - RowW'(1));
      left_q  <= (ocol == '0);
      right_q <= (ocol == w_eff - WW'(1));
      fe_q    <= fe_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (cmd_i.update) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= rd_q[47:24];
      win_q[5] <= rd_q[23:0];
      win_q[8] <= pix_q;
    end
  end

  always_comb begin
    logic signed [10:0] c [9];
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        c[k] = {3'b000, win_q[k][(2-ch)*8 +: 8]};
        if ((top_q && k < 3) || (bot_q && k > 5) ||
            (left_q && (k % 3) == 0) || (right_q && (k % 3) == 2)) c[k] = '0;
      end
      gx_d[ch] = c[2] - c[0] + ((c[5] - c[3]) <<< 1) + c[8] - c[6];
      gy_d[ch] = c[6] - c[0] + ((c[7] - c[1]) <<< 1) + c[8] - c[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      for (int ch = 0; ch < 3; ch++) begin
        gx_q[ch] <= gx_d[ch];
        gy_q[ch] <= gy_d[ch];
      end
    end
  end

  // Square sum, then a digit-by-digit root: two bits of the sum per step.
  always_ff @(posedge clk_i) begin
    logic signed [21:0] px, py;
    logic [20:0]        s;
    logic [11:0]        remx, trial;
    for (int ch = 0; ch < 3; ch++) begin
      px = gx_q[ch] * gx_q[ch];
      py = gy_q[ch] * gy_q[ch];
      s  = px[20:0] + py[20:0];
      remx  = {rem_q[ch], sq_q[ch][15:14]};
      trial = {2'b00, root_q[ch], 2'b01};
      if (cmd_i.square) begin
        sq_q[ch]   <= s[15:0];
        sat_q[ch]  <= (s > SatLimit);
        rem_q[ch]  <= '0;
        root_q[ch] <= '0;
      end else if (cmd_i.root_step) begin
        sq_q[ch] <= {sq_q[ch][13:0], 2'b00};
        if (remx >= trial) begin
          rem_q[ch]  <= 10'(remx - trial);
          root_q[ch] <= {root_q[ch][6:0], 1'b1};
        end else begin
          rem_q[ch]  <= remx[9:0];
          root_q[ch] <= {root_q[ch][6:0], 1'b0};
        end
      end
    end
  end

  // The remainder is the sum minus the root squared; above the root rounds up.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (sat_q[ch]) res[ch] = PixMax;
      else if ((rem_q[ch] > {2'b00, root_q[ch]}) && (root_q[ch] != PixMax))
        res[ch] = root_q[ch] + 8'd1;
      else res[ch] = root_q[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      for (int ch = 0; ch < 3; ch++) out_q[ch] <= res[ch];
      out_fe_q <= fe_q;
    end
  end

  assign stat_o.have     = have;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.pos_zero = (col_q == '0) && (row_q == '0);

  assign out_valid_o  = out_valid_q;
  assign edge_red_o   = out_q[0];
  assign edge_green_o = out_q[1];
  assign edge_blue_o  = out_q[2];
  assign frame_end_o  = out_fe_q;

endmodule

// ===== hw/rtl/sobel_edge_magnitude_rgb_unit.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude unit, RGB
// 3x3 Sobel gradient magnitude per color channel over a raster pixel stream.
// ---------------------------------------------------------------------------
//  channel | signals                                  | direction
//  input   | in_valid_i, in_stall_o, op_i, in_*_i     | in
//  output  | out_valid_o, out_stall_i, edge_*_o, frame_end_o | out
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in
//
// A word with no result returns to idle after the update step; a word with a
// result passes gradient, square, the 8 digit-by-digit root steps and output.
// The line buffer memory is read into a register ahead of the update step.
// Reset is asynchronous; no clearing pass is needed, since unwritten rows are
// always masked as outside the frame. A stalled result holds the next word in
// the output step until the result is taken. A register write offered in the
// same cycle as an input word goes first and stalls the word for that cycle.
module sobel_edge_magnitude_rgb_unit import sobel_pkg::*; #(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [7:0]          in_red_i,
  input  logic [7:0]          in_green_i,
  input  logic [7:0]          in_blue_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          edge_red_o,
  output logic [7:0]          edge_green_o,
  output logic [7:0]          edge_blue_o,
  output logic                frame_end_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t stat;
  logic    idle;

  assign in_stall_o  = !idle || cfg_valid_i;
  assign cfg_ready_o = idle;

  sobel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i && !cfg_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  sobel_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_valid_i && idle),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .edge_red_o   (edge_red_o),
    .edge_green_o (edge_green_o),
    .edge_blue_o  (edge_blue_o),
    .frame_end_o  (frame_end_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while previous word still in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> stat.pos_zero)
    else $error("register write did not restart the frame position");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

// ===== tb/tb_sobel_edge_magnitude_rgb_unit.sv =====
// ---------------------------------------------------------------------------
// Testbench for the RGB Sobel edge magnitude unit
// Streams frames of pixel words plus their flush words and checks every
// result against a cycle-free model of the line buffers, the 3x3 window and
// the saturated gradient magnitude. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude_rgb_unit;
  import sobel_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } edge_word_t;

  class edge_scoreboard;
    logic [WidthRegW-1:0]  width_reg;
    logic [HeightRegW-1:0] height_reg;
    logic [23:0]           upper_row [DefMaxWidth];
    logic [23:0]           middle_row [DefMaxWidth];
    logic [23:0]           window [9];
    int unsigned           column;
    int unsigned           row;
    edge_word_t            expected_q [$];
    int                    error_count;

    function new();
      width_reg  = WidthReset;
      height_reg = HeightReset;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      column      = 0;
      row         = 0;
      error_count = 0;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > DefMaxWidth) w = DefMaxWidth;
      return w;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void note_config(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_WIDTH) width_reg = data[WidthRegW-1:0];
      else height_reg = data[HeightRegW-1:0];
      column = 0;
      row    = 0;
    endfunction

    // Rounded square root, saturated at the pixel maximum.
    function logic [7:0] round_root(int unsigned s);
      int unsigned r;
      int unsigned t;
      if (s > SatLimit) return PixMax;
      r = 0;
      for (int b = 128; b != 0; b = b >> 1) begin
        t = r | b;
        if (t * t <= s) r = t;
      end
      if (s - r * r > r) r++;
      return (r > 255) ? PixMax : r[7:0];
    endfunction

    function logic [7:0] channel_mag(logic [23:0] v [9], int shift);
      int gx;
      int gy;
      int c [9];
      for (int i = 0; i < 9; i++) c[i] = (v[i] >> shift) & 8'hFF;
      gx = c[2] - c[0] + 2 * (c[5] - c[3]) + c[8] - c[6];
      gy = c[6] - c[0] + 2 * (c[7] - c[1]) + c[8] - c[2];
      return round_root(gx * gx + gy * gy);
    endfunction

    function void note_input(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned rw;
      int unsigned ocol;
      int unsigned orow;
      logic [23:0] pix;
      logic [23:0] up;
      logic [23:0] mid;
      logic [23:0] v [9];
      logic        have;
      edge_word_t  res;
      w   = eff_width();
      h   = eff_height();
      col = (column >= w) ? 0 : column;
      rw  = row;
      pix = op ? 24'h0 : {r, g, b};
      up  = upper_row[col];
      mid = middle_row[col];
      upper_row[col]  = mid;
      middle_row[col] = pix;
      for (int i = 0; i < 3; i++) begin
        window[i*3]   = window[i*3+1];
        window[i*3+1] = window[i*3+2];
      end
      window[2] = up;
      window[5] = mid;
      window[8] = pix;
      // The window center lags the stream by one row and one pixel.
      have = 1'b0;
      ocol = 0;
      orow = 0;
      if (col == 0) begin
        if (rw >= 2) begin
          have = 1'b1;
          ocol = w - 1;
          orow = rw - 2;
        end
      end else if (rw >= 1) begin
        have = 1'b1;
        ocol = col - 1;
        orow = rw - 1;
      end
      if (have && orow >= h) have = 1'b0;
      col++;
      if (col >= w) begin
        col = 0;
        rw++;
      end
      if (rw > 13'h1FFF) rw = 13'h1FFF;
      column = col;
      row    = rw;
      if (!have) return;
      v = window;
      if (orow == 0) begin
        v[0] = '0; v[1] = '0; v[2] = '0;
      end
      if (orow == h - 1) begin
        v[6] = '0; v[7] = '0; v[8] = '0;
      end
      if (ocol == 0) begin
        v[0] = '0; v[3] = '0; v[6] = '0;
      end
      if (ocol == w - 1) begin
        v[2] = '0; v[5] = '0; v[8] = '0;
      end
      res.red       = channel_mag(v, 16);
      res.green     = channel_mag(v, 8);
      res.blue      = channel_mag(v, 0);
      res.frame_end = (orow == h - 1) && (ocol == w - 1);
      if (res.frame_end) begin
        column = 0;
        row    = 0;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(edge_word_t act);
      edge_word_t exp_w;
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", act);
        error_count++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (act.red !== exp_w.red) begin
        $error("edge_red: expected %0d, got %0d", exp_w.red, act.red);
        error_count++;
      end
      if (act.green !== exp_w.green) begin
        $error("edge_green: expected %0d, got %0d", exp_w.green, act.green);
        error_count++;
      end
      if (act.blue !== exp_w.blue) begin
        $error("edge_blue: expected %0d, got %0d", exp_w.blue, act.blue);
        error_count++;
      end
      if (act.frame_end !== exp_w.frame_end) begin
        $error("frame_end: expected %0d, got %0d", exp_w.frame_end, act.frame_end);
        error_count++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                op_i;
  logic [7:0]          in_red_i;
  logic [7:0]          in_green_i;
  logic [7:0]          in_blue_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          edge_red_o;
  logic [7:0]          edge_green_o;
  logic [7:0]          edge_blue_o;
  logic                frame_end_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  cfg_idx_e            cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  edge_scoreboard sb;
  int             send_idle_pct;
  int             recv_idle_pct;
  bit             hold_request;
  int             random_words;

  sobel_edge_magnitude_rgb_unit u_dut (.*);

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #40_000_000;
    $display("tb_sobel_edge_magnitude_rgb_unit: done, errors");
    $finish;
  end

  // Output side: stall policy at the falling edge, checking at the rising edge.
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result({edge_red_o, edge_green_o, edge_blue_o, frame_end_o});
    end
  end

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_word(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    in_red_i   <= r;
    in_green_i <= g;
    in_blue_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, r, g, b);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    // A word with no result may still be in flight.
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_frame(logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h);
    wait_drained();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One frame plus flush words; with noise, op is sometimes flipped and the
  // frame may be cut short, after which a register write restarts it.
  task automatic run_frame(bit noise);
    int unsigned w;
    int unsigned n;
    int unsigned stop_at;
    logic        op;
    w       = sb.eff_width();
    n       = w * sb.eff_height();
    stop_at = (noise && $urandom_range(7) == 0) ? $urandom_range(n + w) : n + w + 1;
    for (int unsigned i = 0; i < n + w + 1; i++) begin
      if (i == stop_at) begin
        set_frame(sb.width_reg, sb.height_reg);
        return;
      end
      op = (i >= n);
      if (noise && $urandom_range(19) == 0) op = ~op;
      send_word(op, rand_chan(), rand_chan(), rand_chan());
      random_words++;
    end
  endtask

  initial begin : stimulus
    int phase_w [9] = '{5, 8, 2, 1, 16, 3, 4, 6, 9};
    int phase_h [9] = '{4, 3, 6, 7, 5, 1, 2, 6, 4};
    int k;
    sb            = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b0;
    random_words  = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = 1'b0;
    in_red_i      = '0;
    in_green_i    = '0;
    in_blue_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_WIDTH;
    cfg_data_i    = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: a 3x3 frame of extreme values with a black flush word inside,
    // then a single-pixel frame.
    set_frame(3, 3);
    send_word(1'b0, 8'hFF, 8'h00, 8'hFF);
    send_word(1'b0, 8'h00, 8'hFF, 8'h00);
    send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_word(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_word(1'b0, 8'h00, 8'h00, 8'h00);
    send_word(1'b0, 8'hFF, 8'h00, 8'hFF);
    send_word(1'b0, 8'h00, 8'hFF, 8'h00);
    send_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
    for (int i = 0; i < 4; i++) send_word(1'b1, 8'h00, 8'h00, 8'h00);
    set_frame(1, 1);
    send_word(1'b0, 8'hFF, 8'h80, 8'h01);
    send_word(1'b0, 8'h55, 8'hAA, 8'h00);
    send_word(1'b1, 8'h00, 8'h00, 8'h00);

    // Out-of-range register values.
    set_frame(0, 0);
    run_frame(1'b0);

    send_idle_pct = 32;
    recv_idle_pct = 57;
    k = 0;
    random_words = 0;
    while (random_words < 1350) begin
      if (random_words > 900) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_words > 450) begin
        send_idle_pct = 57;
        recv_idle_pct = 32;
      end
      set_frame(phase_w[k % 9], phase_h[k % 9]);
      if (k == 3) hold_request = 1'b1;
      if (k == 5) begin
        for (int i = 0; i < 10; i++)
          send_word(1'b0, rand_chan(), rand_chan(), rand_chan());
        // Let every pending result drain, then restart the frame with register writes.
        in_valid_i <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk_i);
        set_frame(phase_w[k % 9], phase_h[k % 9]);
      end
      for (int f = 0; f < 3; f++) run_frame(1'b1);
      k++;
    end

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (sb.error_count == 0 && sb.expected_q.size() == 0)
      $display("tb_sobel_edge_magnitude_rgb_unit: done, clean");
    else
      $display("tb_sobel_edge_magnitude_rgb_unit: done, errors");
    $finish;
  end

endmodule
